// File: sv/sha1s_pkg.sv
// ----------------------------------------------------------------------------
// sha1s_pkg
// Shared types and constants for the SHA-1 stream hasher.
// ----------------------------------------------------------------------------
package sha1s_pkg;

  localparam logic [31:0] H_INIT0 = 32'h67452301;
  localparam logic [31:0] H_INIT1 = 32'hEFCDAB89;
  localparam logic [31:0] H_INIT2 = 32'h98BADCFE;
  localparam logic [31:0] H_INIT3 = 32'h10325476;
  localparam logic [31:0] H_INIT4 = 32'hC3D2E1F0;

  localparam logic [31:0] K_ROUND0 = 32'h5A827999;
  localparam logic [31:0] K_ROUND1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_ROUND2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_ROUND3 = 32'hCA62C1D6;

  // round counter boundaries
  localparam logic [6:0] RND_LOAD_END = 7'd16;
  localparam logic [6:0] RND_GRP1     = 7'd20;
  localparam logic [6:0] RND_GRP2     = 7'd40;
  localparam logic [6:0] RND_GRP3     = 7'd60;
  localparam logic [6:0] RND_LAST     = 7'd79;

  // word slots of the length field inside a block
  localparam logic [3:0] WIDX_LEN_HI = 4'd14;
  localparam logic [3:0] WIDX_LEN_LO = 4'd15;

  // one 32-bit block word handed from the front to the back
  typedef struct packed {
    logic [31:0] word;
    logic        msg_end;
  } sha1s_qitem_t;

  typedef enum logic {
    F_DATA,
    F_PAD
  } sha1s_front_state_t;

  typedef enum logic {
    B_ROUND,
    B_FINAL
  } sha1s_back_state_t;

endpackage

// File: sv/sha1s_queue.sv
// ----------------------------------------------------------------------------
// sha1s_queue
// Short word queue between the padding front and the compression back.
// ----------------------------------------------------------------------------
module sha1s_queue #(
  parameter int DEPTH = 4
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  sha1s_pkg::sha1s_qitem_t push_item,
  output logic                    full,
  input  logic                    pop,
  output sha1s_pkg::sha1s_qitem_t head_item,
  output logic                    not_empty
);
  import sha1s_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
  localparam logic [AW-1:0] PTR_ONE  = AW'(1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);
  localparam logic [CW-1:0] CNT_ONE  = CW'(1);

  sha1s_qitem_t  slots [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [CW-1:0] count;

  logic do_push;
  logic do_pop;

  assign full      = (count == CNT_FULL);
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head_item = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PTR_LAST) ? '0 : wptr + PTR_ONE;
      end
      if (do_pop) begin
        rptr <= (rptr == PTR_LAST) ? '0 : rptr + PTR_ONE;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_ONE;
        2'b01:   count <= count - CNT_ONE;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_item;
    end
  end

endmodule

// File: sv/sha1s_front.sv
// ----------------------------------------------------------------------------
// sha1s_front
// Packs message bytes into big-endian words and appends the SHA-1 padding.
// ----------------------------------------------------------------------------
module sha1s_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    data_valid,
  output logic                    data_ready,
  input  logic [7:0]              data_byte,
  input  logic                    last,
  output logic                    push,
  output sha1s_pkg::sha1s_qitem_t push_item,
  input  logic                    q_full
);
  import sha1s_pkg::*;

  sha1s_front_state_t state, state_next;
  logic [23:0] cur, cur_next;
  logic [1:0]  pos, pos_next;
  logic [3:0]  widx, widx_next;
  logic [60:0] total, total_next;
  logic [60:0] len, len_next;
  logic        need80, need80_next;
  logic        len_ok, len_ok_next;
  logic        accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= F_DATA;
      pos    <= '0;
      widx   <= '0;
      total  <= '0;
      need80 <= 1'b0;
      len_ok <= 1'b0;
    end else begin
      state  <= state_next;
      pos    <= pos_next;
      widx   <= widx_next;
      total  <= total_next;
      need80 <= need80_next;
      len_ok <= len_ok_next;
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    len <= len_next;
  end

  assign accept = data_valid && data_ready;

  always_comb begin
    state_next  = state;
    cur_next    = cur;
    pos_next    = pos;
    widx_next   = widx;
    total_next  = total;
    len_next    = len;
    need80_next = need80;
    len_ok_next = len_ok;
    data_ready  = 1'b0;
    push        = 1'b0;
    push_item   = '{word: 32'h0, msg_end: 1'b0};
    unique case (state)
      F_DATA: begin
        data_ready = !q_full;
        if (accept) begin
          total_next = total + 61'd1;
          if (last) begin
            push      = 1'b1;
            widx_next = widx + 4'd1;
            pos_next  = '0;
            len_next  = total + 61'd1;
            state_next = F_PAD;
            need80_next = (pos == 2'd3);
            // the 0x80 marker in word 14 leaves no room for the length
            len_ok_next = (widx != WIDX_LEN_HI);
            case (pos)
              2'd0:    push_item.word = {data_byte, 24'h800000};
              2'd1:    push_item.word = {cur[7:0], data_byte, 16'h8000};
              2'd2:    push_item.word = {cur[15:0], data_byte, 8'h80};
              default: push_item.word = {cur, data_byte};
            endcase
          end else if (pos == 2'd3) begin
            push           = 1'b1;
            push_item.word = {cur, data_byte};
            widx_next      = widx + 4'd1;
            pos_next       = '0;
          end else begin
            cur_next = {cur[15:0], data_byte};
            pos_next = pos + 2'd1;
          end
        end
      end
      F_PAD: begin
        if (!q_full) begin
          push      = 1'b1;
          widx_next = widx + 4'd1;
          if (need80) begin
            push_item.word = 32'h80000000;
            need80_next    = 1'b0;
            len_ok_next    = (widx != WIDX_LEN_HI);
          end else if (len_ok && widx == WIDX_LEN_HI) begin
            push_item.word = len[60:29];
          end else if (len_ok && widx == WIDX_LEN_LO) begin
            push_item.word    = {len[28:0], 3'b000};
            push_item.msg_end = 1'b1;
            total_next        = '0;
            state_next        = F_DATA;
          end else begin
            // zero fill; a fresh block always has room for the length
            if (widx == WIDX_LEN_LO) begin
              len_ok_next = 1'b1;
            end
          end
        end
      end
      default: begin
        state_next = F_DATA;
      end
    endcase
  end

endmodule

// File: sv/sha1s_back.sv
// ----------------------------------------------------------------------------
// sha1s_back
// Runs 80 SHA-1 rounds per block, one per cycle unless starved; holds digest.
// ----------------------------------------------------------------------------
module sha1s_back (
  input  logic                    clk,
  input  logic                    rst,
  input  sha1s_pkg::sha1s_qitem_t head_item,
  input  logic                    q_not_empty,
  output logic                    pop,
  output logic                    digest_valid,
  input  logic                    digest_ready,
  output logic [31:0]             digest_word0,
  output logic [31:0]             digest_word1,
  output logic [31:0]             digest_word2,
  output logic [31:0]             digest_word3,
  output logic [31:0]             digest_word4
);
  import sha1s_pkg::*;

  sha1s_back_state_t state, state_next;
  logic [6:0]  rnd;
  logic        msg_end;
  logic [31:0] h0, h1, h2, h3, h4;
  logic [31:0] a, b, c, d, e;
  logic [31:0] win [16];

  logic        step;
  logic        finish;
  logic [31:0] w_mix, w_new, w, f, k, tmp;
  logic [31:0] s0, s1, s2, s3, s4;

  assign w_mix = win[13] ^ win[8] ^ win[2] ^ win[0];
  assign w_new = {w_mix[30:0], w_mix[31]};
  assign w     = (rnd < RND_LOAD_END) ? head_item.word : w_new;

  always_comb begin
    if (rnd < RND_GRP1) begin
      f = (b & c) | (~b & d);
      k = K_ROUND0;
    end else if (rnd < RND_GRP2) begin
      f = b ^ c ^ d;
      k = K_ROUND1;
    end else if (rnd < RND_GRP3) begin
      f = (b & c) | (b & d) | (c & d);
      k = K_ROUND2;
    end else begin
      f = b ^ c ^ d;
      k = K_ROUND3;
    end
  end

  assign tmp = {a[26:0], a[31:27]} + f + e + k + w;

  assign s0 = h0 + a;
  assign s1 = h1 + b;
  assign s2 = h2 + c;
  assign s3 = h3 + d;
  assign s4 = h4 + e;

  always_comb begin
    state_next = state;
    step       = 1'b0;
    pop        = 1'b0;
    finish     = 1'b0;
    unique case (state)
      B_ROUND: begin
        if (rnd < RND_LOAD_END) begin
          step = q_not_empty;
          pop  = q_not_empty;
        end else begin
          step = 1'b1;
        end
        if (step && rnd == RND_LAST) begin
          state_next = B_FINAL;
        end
      end
      B_FINAL: begin
        // on a final block, hold while a previous digest still waits to be taken
        finish = !msg_end || !digest_valid || digest_ready;
        if (finish) begin
          state_next = B_ROUND;
        end
      end
      default: begin
        state_next = B_ROUND;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_ROUND;
      rnd          <= '0;
      msg_end      <= 1'b0;
      digest_valid <= 1'b0;
      h0 <= H_INIT0; h1 <= H_INIT1; h2 <= H_INIT2; h3 <= H_INIT3; h4 <= H_INIT4;
      a  <= H_INIT0; b  <= H_INIT1; c  <= H_INIT2; d  <= H_INIT3; e  <= H_INIT4;
    end else begin
      state <= state_next;
      if (finish && msg_end) begin
        digest_valid <= 1'b1;
      end else if (digest_valid && digest_ready) begin
        digest_valid <= 1'b0;
      end
      if (step) begin
        a   <= tmp;
        b   <= a;
        c   <= {b[1:0], b[31:2]};
        d   <= c;
        e   <= d;
        rnd <= rnd + 7'd1;
        if (pop) begin
          msg_end <= head_item.msg_end;
        end
      end
      if (finish) begin
        rnd <= '0;
        if (msg_end) begin
          h0 <= H_INIT0; h1 <= H_INIT1; h2 <= H_INIT2; h3 <= H_INIT3; h4 <= H_INIT4;
          a  <= H_INIT0; b  <= H_INIT1; c  <= H_INIT2; d  <= H_INIT3; e  <= H_INIT4;
        end else begin
          h0 <= s0; h1 <= s1; h2 <= s2; h3 <= s3; h4 <= s4;
          a  <= s0; b  <= s1; c  <= s2; d  <= s3; e  <= s4;
        end
      end
    end
  end

  // schedule window and digest payload carry no reset
  always_ff @(posedge clk) begin
    if (step) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= win[i+1];
      end
      win[15] <= w;
    end
    if (finish && msg_end) begin
      digest_word0 <= s0;
      digest_word1 <= s1;
      digest_word2 <= s2;
      digest_word3 <= s3;
      digest_word4 <= s4;
    end
  end

endmodule

// File: sv/sha1_stream_hasher_unit.sv
// ----------------------------------------------------------------------------
// sha1_stream_hasher_unit
// SHA-1 digest of a byte stream, one byte per item, digest on the last byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (data_valid/data_ready): one message byte per item, first
//   byte first; last marks the final byte of a message. Every message holds
//   at least one byte.
//   Output channel (digest_valid/digest_ready): one item per message carrying
//   the five digest words, digest_word0 most significant.
// Flow: each 64-byte block runs the 80 rounds and then a fold, one block
//   word taken in each of rounds 0-15. The four-word queue lets the
//   byte-wide front run only 16 bytes ahead during rounds 16-79, so rounds
//   0-15 wait on the other 48 bytes.
// Completion: the front writes the padding words (up to one extra block);
//   digest_valid is registered at the final block's fold, which holds
//   while an earlier digest still waits.
// Reset: synchronous; restores the initial chaining words and clears all
//   counters and the queue. No clearing pass is needed.
// Stall: a waiting digest sits in the output register; the next message is
//   accepted and hashed meanwhile, and only the fold of the next final block
//   holds until the waiting digest is taken.
// ----------------------------------------------------------------------------
module sha1_stream_hasher_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  output logic        data_ready,
  input  logic [7:0]  data_byte,
  input  logic        last,
  output logic        digest_valid,
  input  logic        digest_ready,
  output logic [31:0] digest_word0,
  output logic [31:0] digest_word1,
  output logic [31:0] digest_word2,
  output logic [31:0] digest_word3,
  output logic [31:0] digest_word4
);
  import sha1s_pkg::*;

  sha1s_qitem_t push_item;
  sha1s_qitem_t head_item;
  logic         push;
  logic         q_full;
  logic         pop;
  logic         q_not_empty;

  // pack bytes into words and append padding and length
  sha1s_front u_front (
    .clk        (clk),
    .rst        (rst),
    .data_valid (data_valid),
    .data_ready (data_ready),
    .data_byte  (data_byte),
    .last       (last),
    .push       (push),
    .push_item  (push_item),
    .q_full     (q_full)
  );

  // decouple the byte side from the round engine
  sha1s_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .head_item (head_item),
    .not_empty (q_not_empty)
  );

  // compress blocks and hold the digest for the receiver
  sha1s_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_item    (head_item),
    .q_not_empty  (q_not_empty),
    .pop          (pop),
    .digest_valid (digest_valid),
    .digest_ready (digest_ready),
    .digest_word0 (digest_word0),
    .digest_word1 (digest_word1),
    .digest_word2 (digest_word2),
    .digest_word3 (digest_word3),
    .digest_word4 (digest_word4)
  );

endmodule

// File: tb/tb_sha1_stream_hasher_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sha1_stream_hasher_unit
// Self-checking regression for the SHA-1 stream hasher.
// ----------------------------------------------------------------------------
// A behavioral SHA-1 model in this file follows every accepted byte and
// queues the digest each message must produce. A monitor compares every
// accepted digest, word by word, with the oldest queued one. Stimulus runs
// from a few hand-picked short messages, through the padding boundary
// lengths and a long output stall that backs the block up to its input, to
// a random stream of messages with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_sha1_stream_hasher_unit;

  // standard SHA-1 starting chain and round constants
  localparam logic [31:0] SHA1_IV0 = 32'h67452301;
  localparam logic [31:0] SHA1_IV1 = 32'hEFCDAB89;
  localparam logic [31:0] SHA1_IV2 = 32'h98BADCFE;
  localparam logic [31:0] SHA1_IV3 = 32'h10325476;
  localparam logic [31:0] SHA1_IV4 = 32'hC3D2E1F0;
  localparam logic [31:0] SHA1_K0  = 32'h5A827999;
  localparam logic [31:0] SHA1_K1  = 32'h6ED9EBA1;
  localparam logic [31:0] SHA1_K2  = 32'h8F1BBCDC;
  localparam logic [31:0] SHA1_K3  = 32'hCA62C1D6;
  // byte offset in a block where the 64-bit length field starts
  localparam logic [5:0]  LEN_FIELD_POS = 6'd56;

  localparam int RANDOM_BYTES    = 250;
  localparam int RANDOM_MESSAGES = 8;
  localparam int DRAIN_CYCLES    = 400;

  typedef struct {
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [31:0] w3;
    logic [31:0] w4;
  } sha1_digest_t;

  // DUT signals; every input is known from time zero
  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        data_valid   = 1'b0;
  logic        data_ready;
  logic [7:0]  data_byte    = 8'h00;
  logic        last         = 1'b0;
  logic        digest_valid;
  logic        digest_ready = 1'b0;
  logic [31:0] digest_word0;
  logic [31:0] digest_word1;
  logic [31:0] digest_word2;
  logic [31:0] digest_word3;
  logic [31:0] digest_word4;

  // model state, owned by the input monitor
  logic [31:0] chain_h [5];
  logic [7:0]  msg_block [64];
  logic [5:0]  block_fill;
  logic [60:0] msg_bytes;

  sha1_digest_t pending_digests [$];
  int           mismatch_count = 0;

  // receiver controls: short random stalls, plus a long hold on request
  int stall_left = 0;
  int hold_left  = 0;
  bit calm       = 1'b0;

  sha1_stream_hasher_unit uut (
    .clk          (clk),
    .rst          (rst),
    .data_valid   (data_valid),
    .data_ready   (data_ready),
    .data_byte    (data_byte),
    .last         (last),
    .digest_valid (digest_valid),
    .digest_ready (digest_ready),
    .digest_word0 (digest_word0),
    .digest_word1 (digest_word1),
    .digest_word2 (digest_word2),
    .digest_word3 (digest_word3),
    .digest_word4 (digest_word4)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("sha1_stream_hasher_unit regression: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // SHA-1 model
  // --------------------------------------------------------------------------
  function automatic logic [31:0] rol32(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  task automatic reset_chain();
    chain_h[0] = SHA1_IV0;
    chain_h[1] = SHA1_IV1;
    chain_h[2] = SHA1_IV2;
    chain_h[3] = SHA1_IV3;
    chain_h[4] = SHA1_IV4;
    block_fill = '0;
    msg_bytes  = '0;
  endtask

  // Run the 80 rounds over the full block and fold into the chain.
  task automatic compress_block();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, tmp;
    int t;
    for (t = 0; t < 16; t++) begin
      w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
    end
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (t = 0; t < 80; t++) begin
      if (t >= 16) begin
        w[t%16] = rol32(w[(t-3)%16] ^ w[(t-8)%16] ^ w[(t-14)%16] ^ w[t%16], 1);
      end
      if (t < 20) begin
        f = (b & c) | (~b & d);
        k = SHA1_K0;
      end else if (t < 40) begin
        f = b ^ c ^ d;
        k = SHA1_K1;
      end else if (t < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = SHA1_K2;
      end else begin
        f = b ^ c ^ d;
        k = SHA1_K3;
      end
      tmp = rol32(a, 5) + f + e + k + w[t%16];
      e = d;
      d = c;
      c = rol32(b, 30);
      b = a;
      a = tmp;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endtask

  task automatic load_block_byte(input logic [7:0] v);
    msg_block[block_fill] = v;
    block_fill = block_fill + 6'd1;
    if (block_fill == 6'd0) compress_block();
  endtask

  // Absorb one accepted byte; on the last byte pad, finish and queue a digest.
  task automatic absorb_byte(input logic [7:0] v, input logic is_last);
    logic [63:0]  bit_len;
    sha1_digest_t dg;
    int i;
    load_block_byte(v);
    msg_bytes = msg_bytes + 61'd1;
    if (is_last) begin
      bit_len = {msg_bytes, 3'b000};
      load_block_byte(8'h80);
      while (block_fill != LEN_FIELD_POS) load_block_byte(8'h00);
      for (i = 7; i >= 0; i--) load_block_byte(bit_len[8*i +: 8]);
      dg.w0 = chain_h[0];
      dg.w1 = chain_h[1];
      dg.w2 = chain_h[2];
      dg.w3 = chain_h[3];
      dg.w4 = chain_h[4];
      pending_digests.push_back(dg);
      reset_chain();
    end
  endtask

  initial reset_chain();

  // Follow every accepted byte.
  always @(posedge clk) begin
    if (!rst && data_valid && data_ready) absorb_byte(data_byte, last);
  end

  // --------------------------------------------------------------------------
  // Digest checker
  // --------------------------------------------------------------------------
  task automatic check_word(input int idx, input logic [31:0] exp_w, input logic [31:0] act_w);
    if (act_w !== exp_w) begin
      mismatch_count++;
      $display("%0t: digest_word%0d mismatch: expected %08h, actual %08h",
               $time, idx, exp_w, act_w);
    end
  endtask

  always @(posedge clk) begin
    sha1_digest_t dg;
    if (!rst && digest_valid && digest_ready) begin
      if (pending_digests.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected digest: expected none, actual %08h %08h %08h %08h %08h",
                 $time, digest_word0, digest_word1, digest_word2, digest_word3,
                 digest_word4);
      end else begin
        dg = pending_digests.pop_front();
        check_word(0, dg.w0, digest_word0);
        check_word(1, dg.w1, digest_word1);
        check_word(2, dg.w2, digest_word2);
        check_word(3, dg.w3, digest_word3);
        check_word(4, dg.w4, digest_word4);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Gap length: mostly none, some short, a few long; none in calm stretches.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver: honor a requested long hold first, else stall at random.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      digest_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (stall_left > 0) begin
      digest_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      digest_ready <= 1'b1;
      if ($urandom_range(0, 2) == 0) stall_left = pick_gap();
    end
  end

  // Offer one item and hold it until accepted; return at the next falling edge.
  task automatic send_item(input logic [7:0] v, input logic is_last);
    data_valid <= 1'b1;
    data_byte  <= v;
    last       <= is_last;
    @(posedge clk);
    while (!data_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid for an idle gap of length n; n of zero keeps valid up for the next item.
  task automatic idle_sender(input int n);
    if (n > 0) begin
      data_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic send_message(input int len);
    int i;
    for (i = 0; i < len; i++) begin
      send_item(8'($urandom_range(0, 255)), (i == len - 1));
      idle_sender(pick_gap());
    end
  endtask

  // Drop valid so the last item is not offered again, then drain.
  task automatic wait_digests_done();
    data_valid <= 1'b0;
    while (pending_digests.size() != 0) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Hand-picked short messages: byte extremes and mixed patterns.
  task automatic test_short_messages();
    logic [7:0] abc [3];
    int i;
    abc = '{8'h61, 8'h62, 8'h63};
    send_item(8'h00, 1'b1);
    idle_sender(pick_gap());
    send_item(8'hFF, 1'b1);
    idle_sender(pick_gap());
    for (i = 0; i < 3; i++) begin
      send_item(abc[i], (i == 2));
      idle_sender(pick_gap());
    end
    for (i = 0; i < 8; i++) begin
      send_item((i % 2 == 0) ? 8'h55 : 8'hAA, (i == 7));
      idle_sender(pick_gap());
    end
    send_item(8'h80, 1'b0);
    send_item(8'h7F, 1'b1);
    idle_sender(pick_gap());
    wait_digests_done();
  endtask

  // Lengths where padding just fits, just spills, or lands on a block edge.
  task automatic test_pad_boundaries();
    int lens [10];
    int i;
    lens = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
    for (i = 0; i < 10; i++) send_message(lens[i]);
    wait_digests_done();
  endtask

  // Hold the receiver off long enough that the block backs up to its input.
  task automatic test_output_hold();
    int i;
    calm      = 1'b1;
    hold_left = 700;
    for (i = 0; i < 4; i++) send_message(70);
    calm = 1'b0;
    idle_sender(1);
    wait_digests_done();
  endtask

  // Random stream: mostly short messages, some around the padding edge,
  // a few spanning several blocks; calm stretches now and then.
  task automatic test_random_stream();
    int bytes_sent;
    int msgs_sent;
    int r;
    int len;
    bytes_sent = 0;
    msgs_sent  = 0;
    while (bytes_sent < RANDOM_BYTES || msgs_sent < RANDOM_MESSAGES) begin
      calm = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      if (r < 70)      len = $urandom_range(1, 20);
      else if (r < 90) len = $urandom_range(50, 70);
      else             len = $urandom_range(100, 200);
      send_message(len);
      bytes_sent += len;
      msgs_sent++;
    end
    calm = 1'b0;
    idle_sender(1);
    wait_digests_done();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_short_messages();
    test_pad_boundaries();
    test_output_hold();
    test_random_stream();

    // let any stray digest show up before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_digests.size() == 0) begin
      $display("sha1_stream_hasher_unit regression: pass");
    end else begin
      $display("sha1_stream_hasher_unit regression: fail");
    end
    $finish;
  end

endmodule
